### hdl/okl_pkg.sv
// ----------------------------------------------------------------------------
// okl_pkg
// Types and command codes shared by the ordered keyed list table.
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int KEY_W   = 16;
    localparam int DATA_W  = 16;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] client_in;
        logic [DATA_W-1:0] cart_in;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [DATA_W-1:0]  client_out;
        logic [DATA_W-1:0]  cart_out;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] client;
        logic [DATA_W-1:0] cart;
    } t_entry;

    typedef struct packed {
        logic write;    // load a new entry from the append port
        logic shift;    // take the right neighbor's entry (closes a gap)
        logic compare;  // latch the key match for the scan
    } t_cell_ctl;

endpackage

### hdl/okl_cell.sv
// ----------------------------------------------------------------------------
// okl_cell
// One slot of the table: entry, valid bit and a registered key match.
// ----------------------------------------------------------------------------
module okl_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  okl_pkg::t_cell_ctl              i_ctl,
    input  okl_pkg::t_entry                 i_new,
    input  okl_pkg::t_entry                 i_next,
    input  logic                            i_next_valid,
    input  logic [okl_pkg::KEY_W-1:0]       i_key,
    output okl_pkg::t_entry                 o_entry,
    output logic                            o_valid,
    output logic                            o_match
);

    okl_pkg::t_entry r_entry;
    logic            r_valid;
    logic            r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.write) begin
                r_valid <= 1'b1;
            end else if (i_ctl.shift) begin
                r_valid <= i_next_valid;
            end
            if (i_ctl.compare) begin
                r_match <= r_valid && (r_entry.key == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

### hdl/ordered_keyed_list_table.sv
// ----------------------------------------------------------------------------
// ordered_keyed_list_table
// Insertion-ordered table of keyed entries held in a row of cells.
// ----------------------------------------------------------------------------
// Append and no-op: result strobe in the cycle after start, one word per cycle.
// Remove/search: all cells compare at start, then a scan steps one cell per
// cycle; result on the first matching slot, or after the last entry on a miss.
// Remove compacts the tail in the hit cycle by a one-step neighbor shift.
// Synchronous active-low reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_keyed_list_table #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  okl_pkg::t_in_word  i_cmd_word,
    output logic               o_strobe,
    output okl_pkg::t_out_word o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                         r_state, n_state;
    logic [okl_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_strobe, n_strobe;
    okl_pkg::t_out_word             r_result, n_result;

    okl_pkg::t_entry                cell_entry [DEPTH];
    okl_pkg::t_cell_ctl             cell_ctl   [DEPTH];
    logic [DEPTH-1:0]               cell_valid;
    logic [DEPTH-1:0]               cell_match;

    logic                           accept;
    logic                           full;
    logic                           scan_end;
    logic                           scan_hit;
    okl_pkg::t_entry                hit_entry;
    okl_pkg::t_entry                new_entry;

    assign accept    = start && (r_state == S_IDLE);
    assign full      = (r_count == CW'(DEPTH));
    assign scan_end  = (r_idx == r_count);
    assign scan_hit  = !scan_end && cell_match[r_idx[IW-1:0]];
    assign hit_entry = cell_entry[r_idx[IW-1:0]];
    assign new_entry = '{key:    i_cmd_word.key,
                         client: i_cmd_word.client_in,
                         cart:   i_cmd_word.cart_in};

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        okl_pkg::t_entry next_entry;
        logic            next_valid;

        if (i == DEPTH - 1) begin : g_last
            assign next_entry = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_entry = cell_entry[i+1];
            assign next_valid = cell_valid[i+1];
        end

        assign cell_ctl[i].write   = accept && (i_cmd_word.command == okl_pkg::CMD_APPEND)
                                     && !full && (CW'(i) == r_count);
        // every cell from the hit onward takes its right neighbor
        assign cell_ctl[i].shift   = (r_state == S_SCAN) && scan_hit
                                     && (r_cmd == okl_pkg::CMD_REMOVE) && (CW'(i) >= r_idx);
        assign cell_ctl[i].compare = accept;

        okl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl[i]),
            .i_new        (new_entry),
            .i_next       (next_entry),
            .i_next_valid (next_valid),
            .i_key        (i_cmd_word.key),
            .o_entry      (cell_entry[i]),
            .o_valid      (cell_valid[i]),
            .o_match      (cell_match[i])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_result = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd_word.command;
                    unique case (i_cmd_word.command) inside
                        okl_pkg::CMD_APPEND: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_result.overflow = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        okl_pkg::CMD_REMOVE, okl_pkg::CMD_SEARCH: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (scan_hit) begin
                    n_strobe       = 1'b1;
                    n_state        = S_IDLE;
                    n_result.found = 1'b1;
                    if (r_cmd == okl_pkg::CMD_REMOVE) begin
                        n_result.client_out = hit_entry.client;
                        n_result.cart_out   = hit_entry.cart;
                        n_count             = r_count - 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_result.entry_count = okl_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_cmd    <= okl_pkg::CMD_NOP;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_cmd    <= n_cmd;
            r_idx    <= n_idx;
        end
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
